// ----- hw/rtl/tlfq_pkg.sv -----
// Shared types, constants and helpers for the three-level feedback queue scheduler.
// Used by three_level_feedback_queue_scheduler_unit; no dependencies.
package tlfq_pkg;

  // queue geometry
  localparam int MAX_JOBS  = 8;
  localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int NUM_LVL   = 3;
  localparam int RAM_DEPTH = NUM_LVL * MAX_JOBS;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // field widths
  localparam int ID_W    = 3;
  localparam int RUN_W   = 8;
  localparam int ENTRY_W = RUN_W + ID_W;
  localparam int MODE_W  = 2;
  localparam int LVL_W   = 2;
  localparam int CFG_W   = 8;
  localparam int CFGI_W  = 2;

  // event codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DONE   = 2'd2;

  // level codes
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] REG_HIGH_LIMIT = 2'd0;
  localparam logic [CFGI_W-1:0] REG_MED_LIMIT  = 2'd1;
  localparam logic [CFGI_W-1:0] REG_LOW_TMO    = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] HIGH_LIMIT_RST = 8'd2;
  localparam logic [CFG_W-1:0] MED_LIMIT_RST  = 8'd6;
  localparam logic [CFG_W-1:0] LOW_TMO_RST    = 8'd50;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_JOBS);

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_LOOKUP,
    S_EMIT
  } state_t;

  // circular index advance
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(MAX_JOBS - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  // flat store address of one slot on one level
  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                               input logic [IDX_W-1:0] idx);
    return ADDR_W'(lvl) * ADDR_W'(MAX_JOBS) + ADDR_W'(idx);
  endfunction

endpackage

// ----- hw/rtl/tlfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the job entries of all three queues.
module tlfq_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 24
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/three_level_feedback_queue_scheduler_unit.sv -----
// Three-level feedback queue scheduler, top level.
// Depends on tlfq_pkg and tlfq_ram.
//
// Usage:
//  - input channel (in_valid/in_ready, mode, job_id): one event per transaction,
//    add job, quantum expiry or job done.
//  - output channel (out_valid/out_ready): exactly one result per event, giving
//    the job to run next, its level, has_job, demoted, timed_out and rejected.
//  - configuration port (cfg_we, cfg_index, cfg_data): writes the high and medium
//    run limits and the low-level timeout; write only while the block is idle.
// Sequencing: an accepted event passes through the apply, lookup and emit states,
//  as set by the registered-read job store, which is read once for the head being
//  charged, written once, then read again for the new head. No new event is taken
//  until the result of the last one has been loaded into the output register.
// The result sits in an output register, so the next event is accepted while
//  a result still waits; a stalled receiver holds the sequencer only at the
//  point where the following result would be loaded.
// Reset: all queues empty, halt flag cleared, registers back to 2, 6 and 50.
//  The job store itself is not cleared; only entries between head and tail are read.
// After a timeout the block halts: events change nothing and adds are rejected.
module three_level_feedback_queue_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst,
  // event channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlfq_pkg::MODE_W-1:0]   mode,
  input  logic [tlfq_pkg::ID_W-1:0]     job_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlfq_pkg::ID_W-1:0]     next_job,
  output logic [tlfq_pkg::LVL_W-1:0]    next_level,
  output logic                          has_job,
  output logic                          demoted,
  output logic                          timed_out,
  output logic                          rejected,
  // configuration port
  input  logic                          cfg_we,
  input  logic [tlfq_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [tlfq_pkg::CFG_W-1:0]    cfg_data
);

  tlfq_pkg::state_t state, state_next;

  // configuration registers
  logic [tlfq_pkg::CFG_W-1:0] high_limit, med_limit, low_tmo;

  // queue pointers and occupancy, one per level
  logic [tlfq_pkg::IDX_W-1:0] head [tlfq_pkg::NUM_LVL];
  logic [tlfq_pkg::IDX_W-1:0] tail [tlfq_pkg::NUM_LVL];
  logic [tlfq_pkg::CNT_W-1:0] cnt  [tlfq_pkg::NUM_LVL];
  logic                       halted;

  // latched event
  logic [tlfq_pkg::MODE_W-1:0] mode_q;
  logic [tlfq_pkg::ID_W-1:0]   job_q;
  logic                        dem_q, rej_q;

  // update controls
  logic [tlfq_pkg::NUM_LVL-1:0] pop, push;
  logic                         set_halt, dem_next, rej_next;

  // store ports
  logic                          ram_we;
  logic [tlfq_pkg::LVL_W-1:0]    wlvl;
  logic [tlfq_pkg::IDX_W-1:0]    widx;
  logic [tlfq_pkg::ENTRY_W-1:0]  wdata, rdata;
  logic [tlfq_pkg::ADDR_W-1:0]   waddr, raddr;

  // head selection
  logic                         any_job;
  logic [tlfq_pkg::LVL_W-1:0]   top;
  logic [tlfq_pkg::IDX_W-1:0]   head_sel;

  // charge unit
  logic [tlfq_pkg::RUN_W-1:0]   runs_inc;
  logic [tlfq_pkg::CFG_W-1:0]   limit_sel;
  logic                         over_limit, over_tmo;
  logic [tlfq_pkg::ENTRY_W-1:0] charged;

  logic out_load;
  logic ptr_ok;

  // highest non-empty level
  always_comb begin
    any_job = 1'b1;
    top     = tlfq_pkg::LVL_HIGH;
    if (cnt[0] != '0) begin
      top = tlfq_pkg::LVL_HIGH;
    end else if (cnt[1] != '0) begin
      top = tlfq_pkg::LVL_MED;
    end else if (cnt[2] != '0) begin
      top = tlfq_pkg::LVL_LOW;
    end else begin
      any_job = 1'b0;
    end
  end

  always_comb begin
    case (top)
      tlfq_pkg::LVL_HIGH: head_sel = head[0];
      tlfq_pkg::LVL_MED:  head_sel = head[1];
      tlfq_pkg::LVL_LOW:  head_sel = head[2];
      default:            head_sel = head[0];
    endcase
  end

  // the store is always read at the current head of the top level
  assign raddr = tlfq_pkg::addr_of(top, head_sel);

  tlfq_ram #(
    .WIDTH (tlfq_pkg::ENTRY_W),
    .DEPTH (tlfq_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // saturating run charge and limit compare
  always_comb begin
    runs_inc = rdata[tlfq_pkg::ENTRY_W-1:tlfq_pkg::ID_W];
    if (runs_inc != tlfq_pkg::RUN_MAX) begin
      runs_inc = runs_inc + tlfq_pkg::RUN_W'(1);
    end
    limit_sel  = (top == tlfq_pkg::LVL_HIGH) ? high_limit : med_limit;
    over_limit = runs_inc >= limit_sel;
    over_tmo   = runs_inc > low_tmo;
    charged    = {runs_inc, rdata[tlfq_pkg::ID_W-1:0]};
  end

  // event decode: pops, pushes and store write
  always_comb begin
    pop      = '0;
    push     = '0;
    ram_we   = 1'b0;
    wlvl     = tlfq_pkg::LVL_HIGH;
    widx     = tail[0];
    wdata    = charged;
    set_halt = 1'b0;
    dem_next = 1'b0;
    rej_next = 1'b0;
    if (state == tlfq_pkg::S_APPLY) begin
      case (mode_q)
        tlfq_pkg::MODE_ADD: begin
          if (halted || cnt[0] == tlfq_pkg::CNT_FULL) begin
            rej_next = 1'b1;
          end else begin
            ram_we  = 1'b1;
            wdata   = {tlfq_pkg::RUN_W'(0), job_q};
            push[0] = 1'b1;
          end
        end
        tlfq_pkg::MODE_EXPIRE: begin
          if (!halted && any_job) begin
            ram_we = 1'b1;
            case (top)
              tlfq_pkg::LVL_HIGH: begin
                pop[0] = 1'b1;
                if (over_limit && cnt[1] != tlfq_pkg::CNT_FULL) begin
                  push[1]  = 1'b1;
                  dem_next = 1'b1;
                  wlvl     = tlfq_pkg::LVL_MED;
                  widx     = tail[1];
                end else begin
                  push[0] = 1'b1;
                end
              end
              tlfq_pkg::LVL_MED: begin
                pop[1] = 1'b1;
                if (over_limit && cnt[2] != tlfq_pkg::CNT_FULL) begin
                  push[2]  = 1'b1;
                  dem_next = 1'b1;
                  wlvl     = tlfq_pkg::LVL_LOW;
                  widx     = tail[2];
                end else begin
                  push[1] = 1'b1;
                  wlvl    = tlfq_pkg::LVL_MED;
                  widx    = tail[1];
                end
              end
              tlfq_pkg::LVL_LOW: begin
                wlvl = tlfq_pkg::LVL_LOW;
                if (over_tmo) begin
                  // job stays at the head with its new count
                  set_halt = 1'b1;
                  widx     = head[2];
                end else begin
                  pop[2]  = 1'b1;
                  push[2] = 1'b1;
                  widx    = tail[2];
                end
              end
              default: begin
                ram_we = 1'b0;
              end
            endcase
          end
        end
        tlfq_pkg::MODE_DONE: begin
          if (!halted && any_job) begin
            case (top)
              tlfq_pkg::LVL_HIGH: pop[0] = 1'b1;
              tlfq_pkg::LVL_MED:  pop[1] = 1'b1;
              tlfq_pkg::LVL_LOW:  pop[2] = 1'b1;
              default:            pop    = '0;
            endcase
          end
        end
        default: begin
          pop = '0;
        end
      endcase
    end
  end

  assign waddr = tlfq_pkg::addr_of(wlvl, widx);

  // sequencer
  assign in_ready = (state == tlfq_pkg::S_IDLE);
  assign out_load = (state == tlfq_pkg::S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      tlfq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tlfq_pkg::S_APPLY;
        end
      end
      tlfq_pkg::S_APPLY:  state_next = tlfq_pkg::S_LOOKUP;
      tlfq_pkg::S_LOOKUP: state_next = tlfq_pkg::S_EMIT;
      tlfq_pkg::S_EMIT: begin
        if (out_load) begin
          state_next = tlfq_pkg::S_IDLE;
        end
      end
      default: state_next = tlfq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlfq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit <= tlfq_pkg::HIGH_LIMIT_RST;
      med_limit  <= tlfq_pkg::MED_LIMIT_RST;
      low_tmo    <= tlfq_pkg::LOW_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tlfq_pkg::REG_HIGH_LIMIT: high_limit <= cfg_data;
        tlfq_pkg::REG_MED_LIMIT:  med_limit  <= cfg_data;
        tlfq_pkg::REG_LOW_TMO:    low_tmo    <= cfg_data;
        default:                  high_limit <= high_limit;
      endcase
    end
  end

  // queue pointer and occupancy update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tlfq_pkg::NUM_LVL; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        cnt[k]  <= '0;
      end
      halted <= 1'b0;
    end else begin
      for (int k = 0; k < tlfq_pkg::NUM_LVL; k++) begin
        if (pop[k]) begin
          head[k] <= tlfq_pkg::idx_inc(head[k]);
        end
        if (push[k]) begin
          tail[k] <= tlfq_pkg::idx_inc(tail[k]);
        end
        if (push[k] && !pop[k]) begin
          cnt[k] <= cnt[k] + tlfq_pkg::CNT_W'(1);
        end else if (pop[k] && !push[k]) begin
          cnt[k] <= cnt[k] - tlfq_pkg::CNT_W'(1);
        end
      end
      if (set_halt) begin
        halted <= 1'b1;
      end
    end
  end

  // latched event and flags
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q <= mode;
      job_q  <= job_id;
    end
    if (state == tlfq_pkg::S_APPLY) begin
      dem_q <= dem_next;
      rej_q <= rej_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_job   <= any_job ? rdata[tlfq_pkg::ID_W-1:0] : '0;
      next_level <= any_job ? top : tlfq_pkg::LVL_HIGH;
      has_job    <= any_job;
      demoted    <= dem_q;
      timed_out  <= halted;
      rejected   <= rej_q;
    end
  end

  // pointer and occupancy agreement on every level
  always_comb begin
    ptr_ok = 1'b1;
    for (int k = 0; k < tlfq_pkg::NUM_LVL; k++) begin
      if ((head[k] == tail[k]) != (cnt[k] == '0 || cnt[k] == tlfq_pkg::CNT_FULL)) begin
        ptr_ok = 1'b0;
      end
    end
  end

  // checks
  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst) ptr_ok)
    else $error("queue pointers disagree with occupancy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= tlfq_pkg::CNT_FULL && cnt[1] <= tlfq_pkg::CNT_FULL &&
    cnt[2] <= tlfq_pkg::CNT_FULL)
    else $error("queue occupancy beyond capacity");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(halted) |-> halted)
    else $error("halt flag cleared without reset");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_job |-> next_job == '0 && next_level == tlfq_pkg::LVL_HIGH && !demoted)
    else $error("empty result carries a job");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(demoted && rejected) && !(demoted && timed_out))
    else $error("conflicting result flags");

endmodule
